// ===== src/bss_pkg.sv =====
// Shared action codes and cell control/status types for the sorted-insert stack.
package bss_pkg;

  localparam int ACT_W = 3;

  localparam logic [ACT_W-1:0] ACT_PUSH     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_BOT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ_TOP = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FIND     = 3'd5;

  // Write enables broadcast to every cell, already qualified by the beat.
  typedef struct packed {
    logic push_top;
    logic ins;
    logic push_bot;
  } cell_ctl_t;

  // Per-cell flags collected by the top level.
  typedef struct packed {
    logic dup_hit;
    logic find_hit;
  } cell_stat_t;

endpackage

// ===== src/bounded_stack_sorted_insert.sv =====
// Top level of the bounded sorted-insert stack: cell row, fill count and result register.
//
// Usage
//   Input channel (in_valid/in_ready, in_action, in_value): one beat asks for one
//   action: push, sorted insert, push at the bottom, pop, read top, or find.
//   Result channel (out_valid/out_ready): one beat per input beat, in order,
//   carrying the new top (-1 when empty), the find position (-1 when no match or
//   not a find), the fill count and whether the stack changed.
//   The result is registered at the edge that accepts the input. Throughput is
//   one beat per cycle while the receiver keeps up; every cell compares and
//   shifts in the same cycle, so the critical path is one word compare followed
//   by the one-bit stop chain running down the row of DEPTH cells.
//   When the receiver stalls, the held result stays put and in_ready drops until
//   it is taken; in_ready is high whenever the result register is empty or being
//   drained in the same cycle.
//   Reset (rst_n low, synchronous) empties the stack and the result register.
//   Entries are not cleared; only entries below the fill count are ever read.
module bounded_stack_sorted_insert #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bss_pkg::ACT_W-1:0]   in_action,
  input  logic [WORD_WIDTH-1:0]       in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [WORD_WIDTH-1:0]       out_top_value,
  output logic [$clog2(DEPTH):0]      out_find_index,
  output logic [$clog2(DEPTH+1)-1:0]  out_item_count,
  output logic                        out_was_applied
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // Fill count and result register
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic                  out_valid_r;
  logic [WORD_WIDTH-1:0] top_r, top_nxt;
  logic [IDX_W:0]        find_r, find_nxt;
  logic                  applied_r, applied_nxt;

  logic accept;
  logic full;
  logic empty;
  logic dup;
  logic any_hit;
  logic [IDX_W-1:0] hit_idx;

  // Decoded action
  logic op_push, op_ins, op_bot, op_pop, op_find;

  // Cell row wiring
  bss_pkg::cell_ctl_t  ctl;
  bss_pkg::cell_stat_t stat     [DEPTH];
  logic [WORD_WIDTH-1:0] entry     [DEPTH];
  logic [WORD_WIDTH-1:0] entry_nxt [DEPTH];
  logic [DEPTH-1:0] stop_out;
  logic [DEPTH-1:0] fstop_out;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;
  assign full     = fill_r == CNT_W'(DEPTH);
  assign empty    = fill_r == '0;

  always_comb begin
    op_push = 1'b0;
    op_ins  = 1'b0;
    op_bot  = 1'b0;
    op_pop  = 1'b0;
    op_find = 1'b0;
    unique case (in_action)
      bss_pkg::ACT_PUSH:     op_push = 1'b1;
      bss_pkg::ACT_INSERT:   op_ins  = 1'b1;
      bss_pkg::ACT_PUSH_BOT: op_bot  = 1'b1;
      bss_pkg::ACT_POP:      op_pop  = 1'b1;
      bss_pkg::ACT_FIND:     op_find = 1'b1;
      default: ;  // read top and unknown codes touch nothing
    endcase
  end

  // Collect duplicate and find flags from the row
  always_comb begin
    dup     = 1'b0;
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      dup     = dup | stat[i].dup_hit;
      any_hit = any_hit | stat[i].find_hit;
      if (stat[i].find_hit) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // Gate writes: full blocks all pushes, a duplicate drops the insert
  assign ctl.push_top = accept & op_push & ~full;
  assign ctl.ins      = accept & op_ins & ~full & ~dup;
  assign ctl.push_bot = accept & op_bot & ~full;

  always_comb begin
    applied_nxt = ctl.push_top | ctl.ins | ctl.push_bot | (op_pop & ~empty);
    fill_nxt    = fill_r;
    if (ctl.push_top | ctl.ins | ctl.push_bot) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (accept & op_pop & ~empty) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  // New top: the cell just below the new fill count, -1 when empty
  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (fill_nxt == CNT_W'(i + 1)) begin
        top_nxt = top_nxt | entry_nxt[i];
      end
    end
    if (fill_nxt == '0) begin
      top_nxt = '1;
    end
  end

  assign find_nxt = (op_find & any_hit) ? {1'b0, hit_idx} : '1;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_WIDTH-1:0] below_entry;
      logic                  below_stop;
      logic                  stop_in;
      logic                  fstop_in;

      if (g == 0) begin : g_bot
        assign below_entry = '0;
        assign below_stop  = 1'b1;
      end else begin : g_mid
        assign below_entry = entry[g-1];
        assign below_stop  = stop_out[g-1];
      end

      if (g == DEPTH - 1) begin : g_top
        assign stop_in  = 1'b0;
        assign fstop_in = 1'b0;
      end else begin : g_low
        assign stop_in  = stop_out[g+1];
        assign fstop_in = fstop_out[g+1];
      end

      bss_cell #(
        .WORD_WIDTH (WORD_WIDTH),
        .CNT_W      (CNT_W),
        .CELL_IDX   (g)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .fill        (fill_r),
        .value       (in_value),
        .below_entry (below_entry),
        .below_stop  (below_stop),
        .stop_in     (stop_in),
        .stop_out    (stop_out[g]),
        .fstop_in    (fstop_in),
        .fstop_out   (fstop_out[g]),
        .entry       (entry[g]),
        .entry_nxt   (entry_nxt[g]),
        .stat        (stat[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      top_r     <= top_nxt;
      find_r    <= find_nxt;
      applied_r <= applied_nxt;
    end
  end

  logic [CNT_W-1:0] count_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      count_r <= fill_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = top_r;
  assign out_find_index  = find_r;
  assign out_item_count  = count_r;
  assign out_was_applied = applied_r;

endmodule

// ===== src/bss_cell.sv =====
// One stack cell: holds an entry, compares it, and shifts from its lower neighbor.
module bss_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  bss_pkg::cell_ctl_t    ctl,
  input  logic [CNT_W-1:0]      fill,
  input  logic [WORD_WIDTH-1:0] value,
  input  logic [WORD_WIDTH-1:0] below_entry,
  input  logic                  below_stop,
  input  logic                  stop_in,
  output logic                  stop_out,
  input  logic                  fstop_in,
  output logic                  fstop_out,
  output logic [WORD_WIDTH-1:0] entry,
  output logic [WORD_WIDTH-1:0] entry_nxt,
  output bss_pkg::cell_stat_t   stat
);

  logic [WORD_WIDTH-1:0] entry_r;
  logic occ;
  logic lt;
  logic eq;
  logic ng;
  logic match;
  logic at_fill;
  logic wr_ins;
  logic sh_ins;

  assign occ     = CNT_W'(CELL_IDX) < fill;
  assign at_fill = CNT_W'(CELL_IDX) == fill;
  assign lt      = $signed(value) < $signed(entry_r);
  assign eq      = value == entry_r;

  // Insert chain: any occupied entry at or above here that is not above value.
  assign ng       = occ & ~lt;
  assign stop_out = stop_in | ng;
  assign wr_ins   = ~stop_out & below_stop;
  assign sh_ins   = ~below_stop;

  // Find chain: topmost occupied match wins.
  assign match     = occ & eq;
  assign fstop_out = fstop_in | match;

  assign stat.dup_hit  = ng & ~stop_in & eq;
  assign stat.find_hit = match & ~fstop_in;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push_top) begin
      if (at_fill) begin
        entry_nxt = value;
      end
    end else if (ctl.ins) begin
      if (wr_ins) begin
        entry_nxt = value;
      end else if (sh_ins) begin
        entry_nxt = below_entry;
      end
    end else if (ctl.push_bot) begin
      entry_nxt = (CELL_IDX == 0) ? value : below_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== src/bss_checker.sv =====
// Port-level checker for the sorted-insert stack, bound to the top level.
module bss_checker #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [WORD_WIDTH-1:0]       out_top_value,
  input logic [$clog2(DEPTH):0]      out_find_index,
  input logic [$clog2(DEPTH+1)-1:0]  out_item_count,
  input logic                        out_was_applied
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_top_value)
      && $stable(out_item_count) && $stable(out_find_index))
    else $error("stalled result beat changed");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item_count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_find: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_find_index[IDX_W] |->
      CNT_W'(out_find_index[IDX_W-1:0]) < out_item_count
      && !out_was_applied)
    else $error("find position outside held entries");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_count == '0 |-> out_top_value == '1
      && out_find_index == '1)
    else $error("empty stack result not minus one");

endmodule

bind bounded_stack_sorted_insert bss_checker #(
  .DEPTH      (DEPTH),
  .WORD_WIDTH (WORD_WIDTH)
) u_bss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_top_value   (out_top_value),
  .out_find_index  (out_find_index),
  .out_item_count  (out_item_count),
  .out_was_applied (out_was_applied)
);

// ===== verif/tb_bounded_stack_sorted_insert.sv =====
// Self-checking testbench for the bounded sorted-insert stack, with random flow control.
`timescale 1ns / 100ps

module tb_bounded_stack_sorted_insert;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_W      = 32;
  localparam int RAND_BEATS  = 500;     // counted random beats (unknown actions excluded)
  localparam int IDLE_LIMIT  = 2000;    // cycles with no beat on either side
  localparam int LONG_HOLD   = 60;      // receiver hold-off that backs up the input

  // One input beat as queued for the driver.
  typedef struct {
    logic [bss_pkg::ACT_W-1:0] act;
    logic [WORD_W-1:0]         val;
  } stack_req_t;

  // One result beat as the block should report it.
  typedef struct {
    logic [WORD_W-1:0] top;
    logic [4:0]        find_idx;
    logic [4:0]        count;
    logic              applied;
  } stack_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [bss_pkg::ACT_W-1:0] in_action = '0;
  logic [WORD_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] out_top_value;
  logic [4:0] out_find_index;
  logic [4:0] out_item_count;
  logic out_was_applied;

  bounded_stack_sorted_insert #(
    .DEPTH(STACK_DEPTH),
    .WORD_WIDTH(WORD_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_top_value(out_top_value),
    .out_find_index(out_find_index),
    .out_item_count(out_item_count),
    .out_was_applied(out_was_applied)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Beats waiting for the driver, and results the block still owes us.
  stack_req_t pending_reqs[$];
  stack_rsp_t owed_results[$];

  // Shadow copy of the stack contents and fill level.
  logic signed [WORD_W-1:0] shadow_stack [STACK_DEPTH];
  int shadow_fill = 0;

  int error_count = 0;
  int beats_in = 0;
  int beats_out = 0;

  // Coverage tallies for the closing summary.
  int n_full_drop = 0;
  int n_empty_pop = 0;
  int n_dup_drop = 0;
  int n_find_hit = 0;
  int n_find_miss = 0;
  int n_unknown = 0;
  int n_long_holds = 0;
  int peak_fill = 0;

  // Print one line per mismatch (capped so a dead block cannot flood the log) and count it.
  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (error_count < 40)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // Apply one action to the shadow stack and return the result the block should report.
  function automatic stack_rsp_t stack_apply(input logic [bss_pkg::ACT_W-1:0] act,
                                             input logic signed [WORD_W-1:0] v);
    stack_rsp_t rsp;
    int k;
    int i;
    logic is_full;
    rsp.find_idx = 5'h1f;
    rsp.applied  = 1'b0;
    is_full = (shadow_fill >= STACK_DEPTH);
    case (act)
      bss_pkg::ACT_PUSH: begin
        if (!is_full) begin
          shadow_stack[shadow_fill] = v;
          shadow_fill++;
          rsp.applied = 1'b1;
        end else n_full_drop++;
      end
      bss_pkg::ACT_INSERT: begin
        if (!is_full) begin
          // Walk down past the top run of strictly larger entries.
          k = shadow_fill;
          while (k > 0 && v < shadow_stack[k-1]) k--;
          if (k == 0 || shadow_stack[k-1] != v) begin
            for (i = shadow_fill; i > k; i--) shadow_stack[i] = shadow_stack[i-1];
            shadow_stack[k] = v;
            shadow_fill++;
            rsp.applied = 1'b1;
          end else n_dup_drop++;
        end else n_full_drop++;
      end
      bss_pkg::ACT_PUSH_BOT: begin
        if (!is_full) begin
          for (i = shadow_fill; i > 0; i--) shadow_stack[i] = shadow_stack[i-1];
          shadow_stack[0] = v;
          shadow_fill++;
          rsp.applied = 1'b1;
        end else n_full_drop++;
      end
      bss_pkg::ACT_POP: begin
        if (shadow_fill > 0) begin
          shadow_fill--;
          rsp.applied = 1'b1;
        end else n_empty_pop++;
      end
      bss_pkg::ACT_READ_TOP: ;
      bss_pkg::ACT_FIND: begin
        // Topmost match wins.
        for (k = shadow_fill; k > 0; k--) begin
          if (shadow_stack[k-1] == v) begin
            rsp.find_idx = 5'(k - 1);
            break;
          end
        end
        if (rsp.find_idx == 5'h1f) n_find_miss++;
        else n_find_hit++;
      end
      default: n_unknown++;
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    rsp.top   = (shadow_fill > 0) ? shadow_stack[shadow_fill-1] : '1;
    rsp.count = 5'(shadow_fill);
    return rsp;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Values cluster in a narrow band so that duplicates and find hits are common.
  function automatic logic [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return WORD_W'(int'($urandom_range(0, 15)) - 8);
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // Action mix depends on phase: 0 grows the stack toward full, 1 is mixed, 2 drains it.
  function automatic logic [bss_pkg::ACT_W-1:0] pick_action(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 98) return ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd6;
    case (phase)
      0: begin
        if (r < 30) return bss_pkg::ACT_PUSH;
        if (r < 55) return bss_pkg::ACT_INSERT;
        if (r < 70) return bss_pkg::ACT_PUSH_BOT;
        if (r < 78) return bss_pkg::ACT_POP;
        if (r < 88) return bss_pkg::ACT_READ_TOP;
        return bss_pkg::ACT_FIND;
      end
      1: begin
        if (r < 16) return bss_pkg::ACT_PUSH;
        if (r < 32) return bss_pkg::ACT_INSERT;
        if (r < 45) return bss_pkg::ACT_PUSH_BOT;
        if (r < 65) return bss_pkg::ACT_POP;
        if (r < 78) return bss_pkg::ACT_READ_TOP;
        return bss_pkg::ACT_FIND;
      end
      default: begin
        if (r < 10) return bss_pkg::ACT_PUSH;
        if (r < 20) return bss_pkg::ACT_INSERT;
        if (r < 25) return bss_pkg::ACT_PUSH_BOT;
        if (r < 70) return bss_pkg::ACT_POP;
        if (r < 85) return bss_pkg::ACT_READ_TOP;
        return bss_pkg::ACT_FIND;
      end
    endcase
  endfunction

  task automatic queue_req(input logic [bss_pkg::ACT_W-1:0] act,
                           input logic [WORD_W-1:0] val);
    stack_req_t req;
    req.act = act;
    req.val = val;
    pending_reqs.push_back(req);
  endtask

  // Driver: present the next queued beat, hold it until taken, sometimes idle between beats.
  int tx_gap = 0;
  int tx_cycle = 0;
  always @(posedge clk) begin
    stack_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_cycle++;
      if (!in_valid || in_ready) begin
        if (tx_gap > 0 || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end else begin
          req = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          in_action <= req.act;
          in_value  <= req.val;
          // Every third stretch of driver cycles runs back to back, with no gap.
          tx_gap = ((tx_cycle / 150) % 3 == 0) ? 0 : pick_gap();
        end
      end
    end
  end

  // Receiver: random short stalls, quiet stretches, and two long hold-offs that fill the block.
  int rx_stall = 0;
  int rx_cycle = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 300 || rx_cycle == 900) begin
        rx_stall = LONG_HOLD;
        n_long_holds++;
      end else if (rx_stall == 0 && (rx_cycle / 170) % 3 != 0 && $urandom_range(0, 3) == 0) begin
        rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check the result beat against the oldest owed result, then predict the
  // input beat taken at this same edge. Checking first keeps the queue order fixed.
  always @(posedge clk) begin
    stack_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result beat", out_top_value, '0);
        end else begin
          want = owed_results.pop_front();
          if (out_top_value !== want.top)
            report_mismatch("top_value", out_top_value, want.top);
          if (out_find_index !== want.find_idx)
            report_mismatch("find_index", WORD_W'(out_find_index), WORD_W'(want.find_idx));
          if (out_item_count !== want.count)
            report_mismatch("item_count", WORD_W'(out_item_count), WORD_W'(want.count));
          if (out_was_applied !== want.applied)
            report_mismatch("was_applied", WORD_W'(out_was_applied), WORD_W'(want.applied));
        end
      end
      if (in_valid && in_ready) begin
        beats_in++;
        owed_results.push_back(stack_apply(in_action, in_value));
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no beat for %0d cycles, %0d results still owed",
                 $time, IDLE_LIMIT, owed_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int counted;
    int phase;
    logic [bss_pkg::ACT_W-1:0] act;
    logic [WORD_W-1:0] val;

    // Directed opening: empty-stack cases first, then extremes, duplicates and finds.
    queue_req(bss_pkg::ACT_POP,      32'h0000_0000);  // pop on empty: ignored
    queue_req(bss_pkg::ACT_READ_TOP, 32'h0000_0000);  // empty top reads as -1
    queue_req(bss_pkg::ACT_FIND,     32'h0000_0000);  // find on empty: miss
    queue_req(3'd7,                  32'hffff_ffff);  // unknown action
    queue_req(bss_pkg::ACT_PUSH,     32'h7fff_ffff);
    queue_req(bss_pkg::ACT_PUSH,     32'h8000_0000);
    queue_req(bss_pkg::ACT_INSERT,   32'd3);          // larger than top: lands on top
    queue_req(bss_pkg::ACT_INSERT,   32'd3);          // equal to entry beneath: dropped
    queue_req(bss_pkg::ACT_INSERT,   -32'sd5);        // slides under the 3
    queue_req(bss_pkg::ACT_PUSH_BOT, 32'h0000_0000);
    queue_req(bss_pkg::ACT_PUSH_BOT, 32'hffff_ffff);
    queue_req(bss_pkg::ACT_FIND,     32'h7fff_ffff);
    queue_req(bss_pkg::ACT_FIND,     32'h8000_0000);
    queue_req(bss_pkg::ACT_FIND,     32'd42);         // miss on a loaded stack
    queue_req(bss_pkg::ACT_READ_TOP, 32'h0000_0000);
    queue_req(3'd6,                  32'h0000_0000);  // unknown action
    queue_req(bss_pkg::ACT_INSERT,   32'h8000_0000);  // walks down to the other minimum: dropped
    queue_req(bss_pkg::ACT_INSERT,   32'h7fff_ffff);
    queue_req(bss_pkg::ACT_POP,      32'h0000_0000);
    queue_req(bss_pkg::ACT_POP,      32'h0000_0000);
    queue_req(bss_pkg::ACT_PUSH,     32'h5555_5555);
    queue_req(bss_pkg::ACT_PUSH,     32'haaaa_aaaa);
    queue_req(bss_pkg::ACT_FIND,     32'haaaa_aaaa);

    // Random part in phases of 40 counted beats: grow, grow, drain, mixed.
    counted = 0;
    while (counted < RAND_BEATS) begin
      phase = (counted / 40) % 4;
      if (phase == 3) phase = 1;
      else if (phase == 1) phase = 0;
      else if (phase == 0) phase = 0;
      act = pick_action((counted / 40) % 4 == 2 ? 2 : phase);
      val = pick_value();
      queue_req(act, val);
      if (act <= bss_pkg::ACT_FIND) counted++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all beats taken, all results back, then a short wait for stray beats.
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d beats in, %0d out; peak fill %0d of %0d, %0d long receiver hold-offs",
             beats_in, beats_out, peak_fill, STACK_DEPTH, n_long_holds);
    $display("drops: %0d full, %0d empty pop, %0d duplicate; finds %0d hit %0d miss; %0d unknown",
             n_full_drop, n_empty_pop, n_dup_drop, n_find_hit, n_find_miss, n_unknown);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
